[hw/rtl/table_inverse_cdf_sampler_2d_macros.svh]
// Assertion macros shared by the sampler RTL.
// Include by bare file name; bodies are empty when SYNTHESIS is defined.
`ifndef TABLE_INVERSE_CDF_SAMPLER_2D_MACROS_SVH
`define TABLE_INVERSE_CDF_SAMPLER_2D_MACROS_SVH
`ifndef SYNTHESIS
// Check a property on every rising clock edge outside reset.
`define TICDS_ASSERT(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
	else $error("ticds assertion failed");
// Check that a condition never holds outside reset.
`define TICDS_ASSERT_NEVER(lbl, clk, rstn, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
	else $error("ticds forbidden condition");
`else
`define TICDS_ASSERT(lbl, clk, rstn, prop)
`define TICDS_ASSERT_NEVER(lbl, clk, rstn, cond)
`endif
`endif

[hw/rtl/ticds_pkg.sv]
// Types and constants of the 2D inverse-CDF sampler.
// Used by the divider and the top-level module through scoped names; depends on nothing.
`default_nettype none
package ticds_pkg;
	localparam int ENERGY_POINTS = 256;
	localparam int ANGLE_POINTS  = 256;
	localparam int FRACTION_BITS = 16;
	localparam int IDX_W         = 8;
	localparam int CNT_W         = IDX_W + 1;
	localparam int COND_AW       = 2 * IDX_W;
	localparam int POS_W         = 24;
	localparam int DIV_CNT_W     = 5;

	localparam logic [31:0] RST_LOG_BASE = 32'hFDB28BCA;
	localparam logic [23:0] RST_LOG_STEP = 24'd454478;
	localparam logic [23:0] RST_COS_STEP = 24'd65793;
	localparam logic [31:0] RST_POS_THR  = 32'd2405181686;

	localparam logic [FRACTION_BITS:0] FRAC_ONE  = (FRACTION_BITS + 1)'(1) << FRACTION_BITS;
	localparam logic [FRACTION_BITS:0] FRAC_HALF = (FRACTION_BITS + 1)'(1) << (FRACTION_BITS - 1);
	localparam logic [16:0] COS_MAX = 17'd65536;

	typedef enum logic [1:0] {
		REQ_WR_MARG = 2'd0,
		REQ_WR_COND = 2'd1,
		REQ_SAMPLE  = 2'd2
	} req_t;

	typedef enum logic [1:0] {
		CFG_LOG_BASE = 2'd0,
		CFG_LOG_STEP = 2'd1,
		CFG_COS_STEP = 2'd2,
		CFG_POS_THR  = 2'd3
	} cfg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PROBE,
		ST_CMP,
		ST_CLAMP,
		ST_RD_HI,
		ST_FRAC,
		ST_DIV,
		ST_MUL,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic                     start;
		logic [31:0]              num;
		logic [31:0]              den;
	} div_req_t;

	typedef struct packed {
		logic                     busy;
		logic                     done;
		logic [FRACTION_BITS-1:0] quot;
	} div_rsp_t;
endpackage
`default_nettype wire

[hw/rtl/ticds_ram.sv]
// Generic single-write, single-read synchronous RAM with a registered read port.
// Standalone; used for the marginal and conditional CDF tables.
`default_nettype none
module ticds_ram #(
	parameter int AW = 8,
	parameter int DW = 32
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [DW-1:0] wdata,
	input  wire logic [AW-1:0] raddr,
	output logic      [DW-1:0] rdata
);
	logic [DW-1:0] mem [2**AW];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

[hw/rtl/ticds_div.sv]
// Serial restoring divider for interpolation fractions, one quotient bit a cycle.
// Depends on ticds_pkg; computes (num << FRACTION_BITS) / den for num < den.
`default_nettype none
`include "table_inverse_cdf_sampler_2d_macros.svh"
module ticds_div (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire ticds_pkg::div_req_t req,
	output ticds_pkg::div_rsp_t      rsp
);
	logic [31:0]                          rem_q;
	logic [31:0]                          den_q;
	logic [ticds_pkg::FRACTION_BITS-1:0]  quot_q;
	logic [ticds_pkg::DIV_CNT_W-1:0]      cnt_q;
	logic                                 busy_q;
	logic                                 done_q;
	logic [32:0]                          trial;
	logic                                 fits;

	// Shift remainder and test against divisor
	always_comb begin
		trial = {rem_q, 1'b0};
		fits  = trial >= {1'b0, den_q};
	end

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= ticds_pkg::DIV_CNT_W'(ticds_pkg::FRACTION_BITS - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q  <= req.num;
			den_q  <= req.den;
			quot_q <= '0;
		end else if (busy_q) begin
			rem_q  <= fits ? 32'(trial - {1'b0, den_q}) : trial[31:0];
			quot_q <= {quot_q[ticds_pkg::FRACTION_BITS-2:0], fits};
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.quot = quot_q;

	`TICDS_ASSERT(a_start_idle, clk, arst_n, req.start |-> !busy_q)
	`TICDS_ASSERT(a_done_after_busy, clk, arst_n, done_q |-> $past(busy_q))
	`TICDS_ASSERT_NEVER(a_done_busy, clk, arst_n, done_q && busy_q)
endmodule
`default_nettype wire

[hw/rtl/table_inverse_cdf_sampler_2d.sv]
// A sample runs two table inversions, energy then angle, each a binary search of probe
// and compare states, a clamp and a bracket read, and a fraction, from the serial divider
// when the bracket entries do not settle it; then the multiply and output mapping states.
// Throughput: one sample at a time, set by the single read port of each table
// and the serial divider. Reset clears control and loads register defaults;
// table contents stay undefined until written.
`default_nettype none
`include "table_inverse_cdf_sampler_2d_macros.svh"
module table_inverse_cdf_sampler_2d (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// energy_index, angle_index, cdf_word, uniform_energy, uniform_angle, uniform_charge
	input  wire logic [143:0] s_tdata,
	// req_type
	input  wire logic [1:0]   s_tuser,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// energy_position, angle_position, log_energy, cos_zenith, is_positive, zero pad
	output logic      [103:0] m_tdata,
	input  wire logic         cfg_we,
	input  wire logic [1:0]   cfg_index,
	input  wire logic [31:0]  cfg_data
);
	localparam int IW = ticds_pkg::IDX_W;
	localparam int CW = ticds_pkg::CNT_W;
	localparam int FB = ticds_pkg::FRACTION_BITS;

	ticds_pkg::state_t state_q, state_d;

	logic [31:0] base_q, thr_q;
	logic [23:0] lstep_q, cstep_q;
	logic [31:0] ue_q, ua_q, uc_q;
	logic        phase_q;
	logic [CW-1:0] lo_q, count_q;
	logic [IW-1:0] idx_q, eidx_q;
	logic [31:0] lower_q;
	logic [23:0] epos_q, apos_q;
	logic [47:0] prod_e_s1, prod_c_s1;

	logic        in_acc;
	logic [IW-1:0] in_ei, in_ai;
	logic [31:0] in_word;
	logic [IW-1:0] rd_idx, clamp_idx;
	logic [CW-1:0] half, probe;
	logic [31:0] marg_rdata, cond_rdata, rdata, u_cur;
	logic [31:0] diff, num;
	logic        frac_rdy, out_free;
	logic [FB:0] frac_c;
	logic [23:0] pos_c;
	ticds_pkg::div_req_t div_req;
	ticds_pkg::div_rsp_t div_rsp;
	logic signed [33:0] loge_sum;
	logic [31:0] loge_sat;
	logic [16:0] cz_sat;

	assign in_ei   = s_tdata[7:0];
	assign in_ai   = s_tdata[15:8];
	assign in_word = s_tdata[47:16];
	assign in_acc  = s_tvalid && s_tready;
	assign s_tready = state_q == ticds_pkg::ST_IDLE;
	assign out_free = !m_tvalid || m_tready;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q  <= ticds_pkg::RST_LOG_BASE;
			lstep_q <= ticds_pkg::RST_LOG_STEP;
			cstep_q <= ticds_pkg::RST_COS_STEP;
			thr_q   <= ticds_pkg::RST_POS_THR;
		end else if (cfg_we) begin
			unique case (ticds_pkg::cfg_idx_t'(cfg_index))
				ticds_pkg::CFG_LOG_BASE: base_q  <= cfg_data;
				ticds_pkg::CFG_LOG_STEP: lstep_q <= cfg_data[23:0];
				ticds_pkg::CFG_COS_STEP: cstep_q <= cfg_data[23:0];
				ticds_pkg::CFG_POS_THR:  thr_q   <= cfg_data;
			endcase
		end
	end

	// Table read address and data select
	always_comb begin
		half      = count_q >> 1;
		probe     = lo_q + half;
		if (lo_q == '0) begin
			clamp_idx = IW'(1);
		end else if (lo_q > CW'(ticds_pkg::ENERGY_POINTS - 1)) begin
			clamp_idx = IW'(ticds_pkg::ENERGY_POINTS - 1);
		end else begin
			clamp_idx = lo_q[IW-1:0];
		end
		priority case (state_q)
			ticds_pkg::ST_PROBE: rd_idx = probe[IW-1:0];
			ticds_pkg::ST_CLAMP: rd_idx = clamp_idx - IW'(1);
			default:             rd_idx = idx_q;
		endcase
		rdata = phase_q ? cond_rdata : marg_rdata;
		u_cur = phase_q ? ua_q : ue_q;
	end

	ticds_ram #(.AW(IW), .DW(32)) u_marg (
		.clk   (clk),
		.we    (in_acc && s_tuser == ticds_pkg::REQ_WR_MARG),
		.waddr (in_ei),
		.wdata (in_word),
		.raddr (rd_idx),
		.rdata (marg_rdata)
	);

	ticds_ram #(.AW(ticds_pkg::COND_AW), .DW(32)) u_cond (
		.clk   (clk),
		.we    (in_acc && s_tuser == ticds_pkg::REQ_WR_COND),
		.waddr ({in_ei, in_ai}),
		.wdata (in_word),
		.raddr ({eidx_q, rd_idx}),
		.rdata (cond_rdata)
	);

	// Fraction between bracketing entries
	always_comb begin
		diff          = rdata - lower_q;
		num           = u_cur - lower_q;
		frac_rdy      = 1'b0;
		frac_c        = ticds_pkg::FRAC_HALF;
		div_req.start = 1'b0;
		div_req.num   = num;
		div_req.den   = diff;
		if (state_q == ticds_pkg::ST_FRAC) begin
			if (rdata > lower_q) begin
				if (u_cur <= lower_q) begin
					frac_rdy = 1'b1;
					frac_c   = '0;
				end else if (num >= diff) begin
					frac_rdy = 1'b1;
					frac_c   = ticds_pkg::FRAC_ONE;
				end else begin
					div_req.start = 1'b1;
				end
			end else begin
				frac_rdy = 1'b1;
			end
		end else if (state_q == ticds_pkg::ST_DIV && div_rsp.done) begin
			frac_rdy = 1'b1;
			frac_c   = {1'b0, div_rsp.quot};
		end
		pos_c = {idx_q - IW'(1), 16'b0} + 24'(frac_c);
	end

	ticds_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// Output mapping: saturate log-energy, clamp cosine
	always_comb begin
		loge_sum = signed'({{2{base_q[31]}}, base_q}) + signed'({2'b0, prod_e_s1[47:16]});
		if (loge_sum > 34'sh07FFFFFFF) begin
			loge_sat = 32'h7FFFFFFF;
		end else if (loge_sum < -34'sh080000000) begin
			loge_sat = 32'h80000000;
		end else begin
			loge_sat = loge_sum[31:0];
		end
		cz_sat = (prod_c_s1[47:24] > 24'(ticds_pkg::COS_MAX)) ? ticds_pkg::COS_MAX
			: prod_c_s1[40:24];
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ticds_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ticds_pkg::ST_IDLE: begin
				if (in_acc && s_tuser == ticds_pkg::REQ_SAMPLE) state_d = ticds_pkg::ST_PROBE;
			end
			ticds_pkg::ST_PROBE: state_d = ticds_pkg::ST_CMP;
			ticds_pkg::ST_CMP: begin
				if (rdata < u_cur) begin
					state_d = (count_q - half - CW'(1) == '0) ? ticds_pkg::ST_CLAMP
						: ticds_pkg::ST_PROBE;
				end else begin
					state_d = (half == '0) ? ticds_pkg::ST_CLAMP : ticds_pkg::ST_PROBE;
				end
			end
			ticds_pkg::ST_CLAMP: state_d = ticds_pkg::ST_RD_HI;
			ticds_pkg::ST_RD_HI: state_d = ticds_pkg::ST_FRAC;
			ticds_pkg::ST_FRAC, ticds_pkg::ST_DIV: begin
				if (div_req.start) begin
					state_d = ticds_pkg::ST_DIV;
				end else if (frac_rdy) begin
					state_d = phase_q ? ticds_pkg::ST_MUL : ticds_pkg::ST_PROBE;
				end
			end
			ticds_pkg::ST_MUL: state_d = ticds_pkg::ST_OUT;
			ticds_pkg::ST_OUT: begin
				if (out_free) state_d = ticds_pkg::ST_IDLE;
			end
			default: state_d = ticds_pkg::ST_IDLE;
		endcase
	end

	// Search and position datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= 1'b0;
		end else if (in_acc) begin
			phase_q <= 1'b0;
		end else if (frac_rdy && !phase_q) begin
			phase_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ticds_pkg::ST_IDLE: begin
				ue_q    <= s_tdata[79:48];
				ua_q    <= s_tdata[111:80];
				uc_q    <= s_tdata[143:112];
				lo_q    <= '0;
				count_q <= CW'(ticds_pkg::ENERGY_POINTS);
			end
			ticds_pkg::ST_CMP: begin
				if (rdata < u_cur) begin
					lo_q    <= probe + CW'(1);
					count_q <= count_q - half - CW'(1);
				end else begin
					count_q <= half;
				end
			end
			ticds_pkg::ST_CLAMP: idx_q <= clamp_idx;
			ticds_pkg::ST_RD_HI: lower_q <= rdata;
			ticds_pkg::ST_FRAC, ticds_pkg::ST_DIV: begin
				if (frac_rdy && !phase_q) begin
					epos_q  <= pos_c;
					eidx_q  <= idx_q;
					lo_q    <= '0;
					count_q <= CW'(ticds_pkg::ANGLE_POINTS);
				end else if (frac_rdy) begin
					apos_q <= pos_c;
				end
			end
			ticds_pkg::ST_MUL: begin
				prod_e_s1 <= epos_q * lstep_q;
				prod_c_s1 <= apos_q * cstep_q;
			end
			default: begin
			end
		endcase
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (state_q == ticds_pkg::ST_OUT && out_free) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ticds_pkg::ST_OUT && out_free) begin
			m_tdata <= {6'b0, uc_q < thr_q, cz_sat, loge_sat, apos_q, epos_q};
		end
	end

	`TICDS_ASSERT(a_mul_in_angle, clk, arst_n, (state_q == ticds_pkg::ST_MUL) |-> phase_q)
	`TICDS_ASSERT(a_out_load, clk, arst_n,
		$rose(m_tvalid) |-> $past(state_q == ticds_pkg::ST_OUT))
	`TICDS_ASSERT_NEVER(a_div_idle, clk, arst_n, s_tready && div_rsp.busy)
endmodule
`default_nettype wire
